### rtl/crpg_pkg.sv
// ---------------------------------------------------------------------------
// crpg_pkg
// Shared types and constants for the Catmull-Rom point and gradient unit.
// ---------------------------------------------------------------------------
`default_nettype none

package crpg_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int COORD_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int W_W        = 22;                  // weight width, signed
   localparam int PROD_W     = COORD_W + W_W;       // one point times one weight
   localparam int ACC_W      = PROD_W + 3;          // sum of four plus rounding
   localparam int SH_W       = ACC_W - FRAC_W - 1;  // after the divide by 2S
   localparam int R_W        = SH_W + 1;            // room for the negation
   localparam int QUEUE_D    = 4;
   localparam int QPTR_W     = 2;

   localparam logic signed [W_W-1:0]   ONE_Q = W_W'(1) << FRAC_W;
   localparam logic signed [ACC_W-1:0] RND_Q = ACC_W'(1) << FRAC_W;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_POS  = 2'd1,
      OP_GRAD = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      K_LOAD,
      K_EVAL,
      K_REJECT
   } kind_type;

   typedef enum logic {
      REG_LOOP_MODE   = 1'b0,
      REG_POINT_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [IDX_W-1:0]          point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [FRAC_W-1:0]         t_frac;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic [1:0]                status;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      logic     grad;
      logic     negx;
   } ctl_type;

   // classified item passed from front to back
   typedef struct packed {
      ctl_type                   ctl;
      logic [IDX_W-1:0]          p0;
      logic [IDX_W-1:0]          p1;
      logic [IDX_W-1:0]          p2;
      logic [IDX_W-1:0]          p3;
      logic signed [COORD_W-1:0] wx;
      logic signed [COORD_W-1:0] wy;
      logic [FRAC_W-1:0]         u;
      logic [FRAC_W-1:0]         tt;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/crpg_ram.sv
// ---------------------------------------------------------------------------
// crpg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module crpg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem_ff[raddr_a];
         rdata_b <= mem_ff[raddr_b];
      end
   end

endmodule

`default_nettype wire

### rtl/crpg_front.sv
// ---------------------------------------------------------------------------
// crpg_front
// Classifies requests: range check, control point indices, t squared.
// ---------------------------------------------------------------------------
`default_nettype none

module crpg_front (
   input  wire logic                       loop_mode,
   input  wire logic [crpg_pkg::CNT_W-1:0] point_count,
   input  wire crpg_pkg::req_type          req,
   output crpg_pkg::cmd_type               cmd
);

   logic [crpg_pkg::CNT_W-1:0]   n;
   logic [crpg_pkg::CNT_W-1:0]   idx_w;
   logic [crpg_pkg::CNT_W-1:0]   nxt1;
   logic [crpg_pkg::CNT_W-1:0]   nxt2;
   logic                         in_range;
   logic [2*crpg_pkg::FRAC_W-1:0] sq;
   logic [2*crpg_pkg::FRAC_W:0]   sq_rnd;

   always_comb begin
      n = (point_count > crpg_pkg::CNT_W'(crpg_pkg::MAX_POINTS)) ?
          crpg_pkg::CNT_W'(crpg_pkg::MAX_POINTS) : point_count;
      idx_w = {1'b0, req.point_index};
      nxt1  = (idx_w + 1'b1 == n) ? '0 : idx_w + 1'b1;
      nxt2  = (nxt1 + 1'b1 == n) ? '0 : nxt1 + 1'b1;
      in_range = loop_mode ? (idx_w < n) : (idx_w + 3'd3 < n);

      sq     = req.t_frac * req.t_frac;
      sq_rnd = {1'b0, sq} + (2*crpg_pkg::FRAC_W+1)'(1 << (crpg_pkg::FRAC_W - 1));

      cmd.wx   = req.coord_x;
      cmd.wy   = req.coord_y;
      cmd.u    = req.t_frac;
      cmd.tt   = sq_rnd[2*crpg_pkg::FRAC_W-1:crpg_pkg::FRAC_W];
      cmd.ctl.grad = (req.opcode == crpg_pkg::OP_GRAD);
      cmd.ctl.negx = (req.opcode == crpg_pkg::OP_GRAD) && (idx_w == n - 1'b1) &&
                     (req.t_frac == '0);

      // a load always writes the entry it names through p0
      if (loop_mode && (req.opcode != crpg_pkg::OP_LOAD)) begin
         cmd.p0 = (req.point_index == '0) ? crpg_pkg::IDX_W'(n - 1'b1) :
                  req.point_index - 1'b1;
         cmd.p1 = req.point_index;
         cmd.p2 = nxt1[crpg_pkg::IDX_W-1:0];
         cmd.p3 = nxt2[crpg_pkg::IDX_W-1:0];
      end else begin
         cmd.p0 = req.point_index;
         cmd.p1 = req.point_index + 2'd1;
         cmd.p2 = req.point_index + 2'd2;
         cmd.p3 = req.point_index + 2'd3;
      end

      unique case (req.opcode)
         crpg_pkg::OP_LOAD: cmd.ctl.kind = crpg_pkg::K_LOAD;
         crpg_pkg::OP_POS,
         crpg_pkg::OP_GRAD: cmd.ctl.kind = in_range ? crpg_pkg::K_EVAL : crpg_pkg::K_REJECT;
         default:           cmd.ctl.kind = crpg_pkg::K_REJECT;
      endcase
   end

endmodule

`default_nettype wire

### rtl/crpg_queue.sv
// ---------------------------------------------------------------------------
// crpg_queue
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module crpg_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire crpg_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output crpg_pkg::cmd_type      head_cmd
);

   crpg_pkg::cmd_type             slot_ff [crpg_pkg::QUEUE_D];
   logic [crpg_pkg::QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [crpg_pkg::QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [crpg_pkg::QPTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (crpg_pkg::QPTR_W+1)'(crpg_pkg::QUEUE_D));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (crpg_pkg::QPTR_W+1)'(push) - (crpg_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/crpg_back.sv
// ---------------------------------------------------------------------------
// crpg_back
// Point table, weight pipeline, multiply, sum, round and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module crpg_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire crpg_pkg::cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output crpg_pkg::rsp_type      rsp
);

   localparam int CW = crpg_pkg::COORD_W;
   localparam int WW = crpg_pkg::W_W;
   localparam int PW = crpg_pkg::PROD_W;
   localparam int AW = crpg_pkg::ACC_W;
   localparam int FW = crpg_pkg::FRAC_W;

   logic adv;
   logic load_we;

   // stage valid bits and control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   crpg_pkg::ctl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;

   logic [2*CW-1:0] rd0, rd1, rd2, rd3;
   logic [FW-1:0]   u1_ff, tt1_ff;
   logic [FW-1:0]   u2_ff, tt2_ff, ttt2_ff;
   logic signed [CW-1:0] px2_ff [4];
   logic signed [CW-1:0] py2_ff [4];
   logic signed [CW-1:0] px3_ff [4];
   logic signed [CW-1:0] py3_ff [4];
   logic signed [WW-1:0] w3_ff [4];
   logic signed [WW-1:0] w_in [4];
   logic signed [PW-1:0] prx4_ff [4];
   logic signed [PW-1:0] pry4_ff [4];
   logic signed [AW-1:0] sx5_ff [2];
   logic signed [AW-1:0] sy5_ff [2];

   logic [2*FW-1:0] cube;
   logic [2*FW:0]   cube_rnd;
   logic [FW-1:0]   ttt_in;
   logic signed [WW-1:0] t_s, tt_s, ttt_s;

   logic                 rsp_valid_ff;
   crpg_pkg::rsp_type    rsp_ff, rsp_in;
   logic [CW-1:0]        fx, fy;
   logic                 satx, saty;

   assign adv     = !rsp_valid_ff || rsp_ready;
   assign pop     = adv && head_valid;
   assign load_we = pop && (head_cmd.ctl.kind == crpg_pkg::K_LOAD);

   crpg_ram #(.WIDTH(2*CW), .DEPTH(crpg_pkg::MAX_POINTS)) u_ram_lo (
      .clock   (clock),
      .we      (load_we),
      .waddr   (head_cmd.p0),
      .wdata   ({head_cmd.wx, head_cmd.wy}),
      .re      (pop),
      .raddr_a (head_cmd.p0),
      .raddr_b (head_cmd.p1),
      .rdata_a (rd0),
      .rdata_b (rd1)
   );

   crpg_ram #(.WIDTH(2*CW), .DEPTH(crpg_pkg::MAX_POINTS)) u_ram_hi (
      .clock   (clock),
      .we      (load_we),
      .waddr   (head_cmd.p0),
      .wdata   ({head_cmd.wx, head_cmd.wy}),
      .re      (pop),
      .raddr_a (head_cmd.p2),
      .raddr_b (head_cmd.p3),
      .rdata_a (rd2),
      .rdata_b (rd3)
   );

   // t cubed from rounded t squared
   always_comb begin
      cube     = tt1_ff * u1_ff;
      cube_rnd = {1'b0, cube} + (2*FW+1)'(1 << (FW - 1));
      ttt_in   = cube_rnd[2*FW-1:FW];
   end

   // basis weights, Q.16
   always_comb begin
      t_s   = signed'({{(WW-FW){1'b0}}, u2_ff});
      tt_s  = signed'({{(WW-FW){1'b0}}, tt2_ff});
      ttt_s = signed'({{(WW-FW){1'b0}}, ttt2_ff});
      if (c2_ff.grad) begin
         w_in[0] = (t_s <<< 2) - ((tt_s <<< 1) + tt_s) - crpg_pkg::ONE_Q;
         w_in[1] = ((tt_s <<< 3) + tt_s) - ((t_s <<< 3) + (t_s <<< 1));
         w_in[2] = (t_s <<< 3) - ((tt_s <<< 3) + tt_s) + crpg_pkg::ONE_Q;
         w_in[3] = ((tt_s <<< 1) + tt_s) - (t_s <<< 1);
      end else begin
         w_in[0] = (tt_s <<< 1) - ttt_s - t_s;
         w_in[1] = ((ttt_s <<< 1) + ttt_s) - ((tt_s <<< 2) + tt_s) + (crpg_pkg::ONE_Q <<< 1);
         w_in[2] = (tt_s <<< 2) + t_s - ((ttt_s <<< 1) + ttt_s);
         w_in[3] = ttt_s - tt_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= head_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         c1_ff   <= head_cmd.ctl;
         u1_ff   <= head_cmd.u;
         tt1_ff  <= head_cmd.tt;

         c2_ff   <= c1_ff;
         u2_ff   <= u1_ff;
         tt2_ff  <= tt1_ff;
         ttt2_ff <= ttt_in;
         px2_ff[0] <= rd0[2*CW-1:CW];  py2_ff[0] <= rd0[CW-1:0];
         px2_ff[1] <= rd1[2*CW-1:CW];  py2_ff[1] <= rd1[CW-1:0];
         px2_ff[2] <= rd2[2*CW-1:CW];  py2_ff[2] <= rd2[CW-1:0];
         px2_ff[3] <= rd3[2*CW-1:CW];  py2_ff[3] <= rd3[CW-1:0];

         c3_ff <= c2_ff;
         for (int k = 0; k < 4; k++) begin
            w3_ff[k]  <= w_in[k];
            px3_ff[k] <= px2_ff[k];
            py3_ff[k] <= py2_ff[k];
         end

         c4_ff <= c3_ff;
         for (int k = 0; k < 4; k++) begin
            prx4_ff[k] <= PW'(px3_ff[k]) * PW'(w3_ff[k]);
            pry4_ff[k] <= PW'(py3_ff[k]) * PW'(w3_ff[k]);
         end

         // fold the rounding offset into the first pair
         c5_ff <= c4_ff;
         sx5_ff[0] <= AW'(prx4_ff[0]) + AW'(prx4_ff[1]) + crpg_pkg::RND_Q;
         sx5_ff[1] <= AW'(prx4_ff[2]) + AW'(prx4_ff[3]);
         sy5_ff[0] <= AW'(pry4_ff[0]) + AW'(pry4_ff[1]) + crpg_pkg::RND_Q;
         sy5_ff[1] <= AW'(pry4_ff[2]) + AW'(pry4_ff[3]);
      end
   end

   // final sum, halve with rounding, optional negate, clamp
   function automatic logic [CW:0] finish(input logic signed [AW-1:0] a,
                                          input logic signed [AW-1:0] b,
                                          input logic                 negate);
      logic signed [AW-1:0]             tot;
      logic signed [AW-1:0]             sh;
      logic signed [crpg_pkg::R_W-1:0]  r;
      logic                             ovf;
      tot = a + b;
      sh  = tot >>> (FW + 1);
      r   = crpg_pkg::R_W'(sh);
      if (negate) begin
         r = -r;
      end
      ovf = (r[crpg_pkg::R_W-1:CW-1] != '0) && (r[crpg_pkg::R_W-1:CW-1] != '1);
      if (ovf) begin
         finish = {1'b1, r[crpg_pkg::R_W-1], {(CW-1){!r[crpg_pkg::R_W-1]}}};
      end else begin
         finish = {1'b0, r[CW-1:0]};
      end
   endfunction

   always_comb begin
      {satx, fx} = finish(sx5_ff[0], sx5_ff[1], c5_ff.negx);
      {saty, fy} = finish(sy5_ff[0], sy5_ff[1], 1'b0);
      rsp_in = '0;
      unique case (c5_ff.kind)
         crpg_pkg::K_LOAD: begin
            rsp_in.status = crpg_pkg::ST_OK;
         end
         crpg_pkg::K_EVAL: begin
            rsp_in.out_x  = fx;
            rsp_in.out_y  = fy;
            rsp_in.status = (satx || saty) ? crpg_pkg::ST_SAT : crpg_pkg::ST_OK;
         end
         default: begin
            rsp_in.status = crpg_pkg::ST_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v5_ff;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

### rtl/catmull_rom_point_gradient.sv
// ---------------------------------------------------------------------------
// catmull_rom_point_gradient
// Catmull-Rom position and gradient unit over a table of 2-D control points.
// ---------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel carrying one request per beat: load a
//   control point, evaluate a position or evaluate a gradient. rsp_* returns
//   exactly one beat per request, in request order; loads answer with zeros.
//   csr_* writes loop_mode (index 0) and point_count (index 1) while idle.
// Timing:
//   One beat per cycle is sustained in both directions while rsp_ready is
//   high; the table is read at four points per cycle through two dual-read
//   RAM copies, and the back end is a 5-stage multiply/accumulate pipeline
//   behind a 4-entry queue.
// Reset and stall:
//   Reset empties the queue and the pipeline and sets loop_mode to 0 and
//   point_count to 4; table contents are undefined until loaded. When
//   rsp_ready is low the back end holds, the queue fills, then req_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module catmull_rom_point_gradient (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire crpg_pkg::req_type          req,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output crpg_pkg::rsp_type               rsp,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [crpg_pkg::CNT_W-1:0] csr_wdata
);

   logic                       loop_mode_ff;
   logic [crpg_pkg::CNT_W-1:0] point_count_ff;
   crpg_pkg::cmd_type          front_cmd;
   crpg_pkg::cmd_type          head_cmd;
   logic                       q_full;
   logic                       head_valid;
   logic                       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff   <= 1'b0;
         point_count_ff <= crpg_pkg::CNT_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            crpg_pkg::REG_LOOP_MODE:   loop_mode_ff   <= csr_wdata[0];
            crpg_pkg::REG_POINT_COUNT: point_count_ff <= csr_wdata;
         endcase
      end
   end

   crpg_front u_front (
      .loop_mode   (loop_mode_ff),
      .point_count (point_count_ff),
      .req         (req),
      .cmd         (front_cmd)
   );

   assign req_ready = !q_full;

   crpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   crpg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

### rtl/crpg_checker.sv
// ---------------------------------------------------------------------------
// crpg_checker
// Port-level checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module crpg_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire crpg_pkg::rsp_type rsp
);

   localparam int CW = crpg_pkg::COORD_W;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled response beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status != 2'd3)
      else $error("undefined status code");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == crpg_pkg::ST_RANGE |-> rsp.out_x == '0 && rsp.out_y == '0)
      else $error("rejected request returned nonzero coordinates");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == crpg_pkg::ST_SAT |->
         rsp.out_x[CW-2:0] == '1 && !rsp.out_x[CW-1] ||
         rsp.out_x[CW-2:0] == '0 && rsp.out_x[CW-1] ||
         rsp.out_y[CW-2:0] == '1 && !rsp.out_y[CW-1] ||
         rsp.out_y[CW-2:0] == '0 && rsp.out_y[CW-1])
      else $error("saturated status without a clamped coordinate");

endmodule

bind catmull_rom_point_gradient crpg_checker u_crpg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Catmull-Rom point and gradient unit: random
// bursts of loads and evaluations under several loop_mode/point_count
// settings, each response checked against an in-bench spline predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_POINTS  = crpg_pkg::MAX_POINTS;
   localparam int IDX_W       = crpg_pkg::IDX_W;
   localparam int CNT_W       = crpg_pkg::CNT_W;
   localparam int COORD_W     = crpg_pkg::COORD_W;
   localparam int FRAC_W      = crpg_pkg::FRAC_W;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   crpg_pkg::req_type       req = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   crpg_pkg::rsp_type       rsp;
   logic                    csr_we = 1'b0;
   crpg_pkg::csr_index_type csr_index = crpg_pkg::REG_LOOP_MODE;
   logic [CNT_W-1:0]        csr_wdata = '0;

   catmull_rom_point_gradient u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
   logic                      cur_loop = 1'b0;
   logic [CNT_W-1:0]          cur_count = 7'd4;
   bit                        loaded [MAX_POINTS];   // generator view

   crpg_pkg::req_type pending_reqs[$];
   crpg_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      n_eval = 0, n_load = 0, n_sat = 0, n_range = 0;

   function automatic logic [COORD_W-1:0] round_sat(longint acc, bit neg, ref bit sat);
      longint r;
      r = (acc + 64'sd65536) >>> (FRAC_W + 1);
      if (neg) r = -r;
      if (r > 64'sd2147483647) begin
         sat = 1;
         return 32'h7fff_ffff;
      end
      if (r < -64'sd2147483648) begin
         sat = 1;
         return 32'h8000_0000;
      end
      return r[COORD_W-1:0];
   endfunction

   function automatic int eff_count();
      return (cur_count > MAX_POINTS) ? MAX_POINTS : int'(cur_count);
   endfunction

   // Segment taps for index i; returns 0 when out of range.
   function automatic bit segment_taps(int i, output int p[4]);
      int n;
      n = eff_count();
      if (i < 0) return 0;
      if (cur_loop) begin
         if (i >= n) return 0;
         p[0] = (i == 0) ? n - 1 : i - 1;
         p[1] = i;
         p[2] = (i + 1) % n;
         p[3] = (p[2] + 1) % n;
      end else begin
         if (i + 3 >= n) return 0;
         for (int k = 0; k < 4; k++) p[k] = i + k;
      end
      return 1;
   endfunction

   function automatic crpg_pkg::rsp_type spline_predict(crpg_pkg::req_type r);
      crpg_pkg::rsp_type o;
      int      p[4];
      longint  u, tt, ttt, s, w[4], ax, ay;
      bit      sat;
      o = '0;
      sat = 0;
      case (crpg_pkg::opcode_type'(r.opcode))
         crpg_pkg::OP_LOAD: begin
            pt_x[r.point_index] = r.coord_x;
            pt_y[r.point_index] = r.coord_y;
            return o;
         end
         crpg_pkg::OP_NONE: begin
            o.status = crpg_pkg::ST_RANGE;
            return o;
         end
         default: ;
      endcase
      if (!segment_taps(int'(r.point_index), p)) begin
         o.status = crpg_pkg::ST_RANGE;
         return o;
      end
      s = 64'sd65536;
      u = longint'(r.t_frac);
      tt = (u * u + 32768) >>> FRAC_W;
      ttt = (tt * u + 32768) >>> FRAC_W;
      if (r.opcode == crpg_pkg::OP_POS) begin
         w[0] = -ttt + 2*tt - u;
         w[1] = 3*ttt - 5*tt + 2*s;
         w[2] = -3*ttt + 4*tt + u;
         w[3] = ttt - tt;
      end else begin
         w[0] = -3*tt + 4*u - s;
         w[1] = 9*tt - 10*u;
         w[2] = -9*tt + 8*u + s;
         w[3] = 3*tt - 2*u;
      end
      ax = 0;
      ay = 0;
      for (int k = 0; k < 4; k++) begin
         ax += longint'(pt_x[p[k]]) * w[k];
         ay += longint'(pt_y[p[k]]) * w[k];
      end
      o.out_x = round_sat(ax, r.opcode == crpg_pkg::OP_GRAD &&
                          int'(r.point_index) == eff_count() - 1 && r.t_frac == 0, sat);
      o.out_y = round_sat(ay, 0, sat);
      o.status = sat ? crpg_pkg::ST_SAT : crpg_pkg::ST_OK;
      return o;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                     : 32'h8000_0000 + $urandom_range(3);
         default: return COORD_W'(signed'($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   // Queue one item; an evaluation touching an unloaded entry becomes a load of it.
   task automatic push_item(crpg_pkg::opcode_type op, int idx, logic [FRAC_W-1:0] t);
      crpg_pkg::req_type r;
      int      p[4];
      r = '0;
      r.opcode = op;
      r.point_index = idx[IDX_W-1:0];
      r.t_frac = t;
      if ((op == crpg_pkg::OP_POS || op == crpg_pkg::OP_GRAD) && segment_taps(idx, p)) begin
         for (int k = 0; k < 4; k++)
            if (!loaded[p[k]]) begin
               r.opcode = crpg_pkg::OP_LOAD;
               r.point_index = p[k][IDX_W-1:0];
               break;
            end
      end
      if (r.opcode == crpg_pkg::OP_LOAD) begin
         r.coord_x = rand_coord();
         r.coord_y = rand_coord();
         loaded[r.point_index] = 1;
      end else begin
         r.coord_x = $urandom();
         r.coord_y = $urandom();
      end
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic random_phase(int count);
      int n, idx, lim;
      logic [FRAC_W-1:0] t;
      n = eff_count();
      lim = cur_loop ? n : n - 3;
      // directed corners for this setting
      push_item(crpg_pkg::OP_GRAD, n - 1, 16'h0000);
      push_item(crpg_pkg::OP_POS, 0, 16'h0000);
      push_item(crpg_pkg::OP_POS, 0, 16'hffff);
      push_item(crpg_pkg::OP_GRAD, 0, 16'hffff);
      for (int j = 0; j < count; j++) begin
         if ($urandom_range(9) < 8 && lim > 0) idx = $urandom_range(lim - 1);
         else idx = $urandom_range(MAX_POINTS - 1);
         case ($urandom_range(7))
            0: t = 16'h0000;
            1: t = 16'hffff;
            default: t = $urandom();
         endcase
         case ($urandom_range(19))
            0, 1, 2: push_item(crpg_pkg::OP_LOAD, $urandom_range(MAX_POINTS - 1), t);
            3: push_item(crpg_pkg::OP_NONE, idx, t);
            4, 5, 6, 7, 8, 9, 10, 11: push_item(crpg_pkg::OP_POS, idx, t);
            default: push_item(crpg_pkg::OP_GRAD, idx, t);
         endcase
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(crpg_pkg::csr_index_type i, logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      if (i == crpg_pkg::REG_LOOP_MODE) cur_loop = v[0];
      else cur_count = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps = {expected_rsps, spline_predict(req)};
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern from one of four randomly chosen modes
   int stall_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 256 == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(9) < 7;
         2: rsp_ready <= (cycles % 8) < 2;
         default: rsp_ready <= $urandom_range(1);
      endcase
      if (cycles >= CYCLE_LIMIT) begin
         $display("catmull_rom_point_gradient regression: fail");
         $finish;
      end
   end

   // monitor
   always @(posedge clock) begin
      crpg_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response beat x=%h y=%h status=%0d",
                   rsp.out_x, rsp.out_y, rsp.status);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.out_x !== e.out_x) begin
               $error("out_x expected %h got %h", e.out_x, rsp.out_x);
               errors++;
            end
            if (rsp.out_y !== e.out_y) begin
               $error("out_y expected %h got %h", e.out_y, rsp.out_y);
               errors++;
            end
            if (rsp.status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp.status);
               errors++;
            end
            case (e.status)
               crpg_pkg::ST_SAT: n_sat++;
               crpg_pkg::ST_RANGE: n_range++;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock)
      if (!reset && req_valid && req_ready) begin
         if (req.opcode == crpg_pkg::OP_LOAD) n_load++;
         else n_eval++;
      end

   initial begin
      crpg_pkg::req_type r;
      for (int k = 0; k < MAX_POINTS; k++) begin
         loaded[k] = 0;
         pt_x[k] = '0;
         pt_y[k] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed at reset settings: extreme points, every opcode, range edges
      r = '0;
      r.opcode = crpg_pkg::OP_LOAD;
      r.point_index = 0; r.coord_x = 32'h7fff_ffff; r.coord_y = 32'h8000_0000;
      pending_reqs = {pending_reqs, r};
      r.point_index = 1; r.coord_x = 32'h8000_0000; r.coord_y = 32'h7fff_ffff;
      pending_reqs = {pending_reqs, r};
      r.point_index = 2; r.coord_x = 32'h7fff_ffff; r.coord_y = 32'hffff_ffff;
      pending_reqs = {pending_reqs, r};
      r.point_index = 3; r.coord_x = 32'h8000_0000; r.coord_y = 32'h0000_0000;
      pending_reqs = {pending_reqs, r};
      for (int k = 0; k < 4; k++) loaded[k] = 1;
      push_item(crpg_pkg::OP_POS, 0, 16'h0000);
      push_item(crpg_pkg::OP_POS, 0, 16'hffff);
      push_item(crpg_pkg::OP_POS, 0, 16'h8000);
      push_item(crpg_pkg::OP_GRAD, 0, 16'h0000);
      push_item(crpg_pkg::OP_GRAD, 0, 16'hffff);
      push_item(crpg_pkg::OP_POS, 1, 16'h4000);
      push_item(crpg_pkg::OP_GRAD, 63, 16'h1234);
      push_item(crpg_pkg::OP_NONE, 0, 16'h0000);
      push_item(crpg_pkg::OP_NONE, 63, 16'hffff);
      drain();

      random_phase(110);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd1);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd64);
      random_phase(150);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd0);
      random_phase(130);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd1);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd1);
      random_phase(80);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd0);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd127);
      random_phase(120);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd1);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd0);
      random_phase(50);
      drain();
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd2);
      random_phase(80);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd0);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'd4);
      random_phase(80);
      drain();
      write_csr(crpg_pkg::REG_LOOP_MODE, 7'd1);
      write_csr(crpg_pkg::REG_POINT_COUNT, 7'($urandom_range(64, 3)));
      random_phase(200);
      drain();

      $display("covered %0d evaluations and %0d loads over 9 settings", n_eval, n_load);
      $display("responses flagged: %0d saturated, %0d out of range", n_sat, n_range);
      if (errors == 0)
         $display("catmull_rom_point_gradient regression: pass");
      else
         $display("catmull_rom_point_gradient regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/crpg_pkg.sv
rtl/crpg_ram.sv
rtl/crpg_front.sv
rtl/crpg_queue.sv
rtl/crpg_back.sv
rtl/catmull_rom_point_gradient.sv
rtl/crpg_checker.sv
tb/tb.sv
